// ----- design/gbsr_pkg.sv -----
// Shared types and constants for the Gershgorin bounds block.
package gbsr_pkg;

   localparam int unsigned MAX_ROWS = 65536;

   localparam logic [16:0] ROWS_RESET = 17'd65536;
   localparam logic [46:0] RAD_MAX = {47{1'b1}};
   localparam logic signed [47:0] B48_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] B48_MIN = {1'b1, {47{1'b0}}};

   typedef struct packed {
      logic signed [31:0] diag;
      logic [46:0] radius;
      logic fold;
      logic mend;
      logic sat;
   } snap_type;

   typedef struct packed {
      logic signed [47:0] lower;
      logic signed [47:0] upper;
      logic sat;
   } bounds_type;

endpackage

// ----- design/gbsr_fold.sv -----
// Running minimum and maximum of the row circles, folded one finished row at a time.
module gbsr_fold (
   input  logic clock,
   input  logic reset,
   input  logic take,
   input  gbsr_pkg::snap_type snap,
   output gbsr_pkg::bounds_type bounds
);

   logic signed [47:0] run_min_ff, run_min_in;
   logic signed [47:0] run_max_ff, run_max_in;
   logic sat_seen_ff, sat_seen_in;

   logic signed [48:0] diag_ext;
   logic signed [48:0] hi_sum;
   logic signed [48:0] lo_sum;
   logic signed [47:0] hi_clamp;
   logic signed [47:0] lo_clamp;

   always_comb begin
      diag_ext = {{17{snap.diag[31]}}, snap.diag};
      hi_sum = diag_ext + $signed({2'b00, snap.radius});
      lo_sum = diag_ext - $signed({2'b00, snap.radius});
      hi_clamp = (hi_sum[48] != hi_sum[47]) ? gbsr_pkg::B48_MAX : hi_sum[47:0];
      lo_clamp = (lo_sum[48] != lo_sum[47]) ? gbsr_pkg::B48_MIN : lo_sum[47:0];

      bounds.upper = (snap.fold && (hi_clamp > run_max_ff)) ? hi_clamp : run_max_ff;
      bounds.lower = (snap.fold && (lo_clamp < run_min_ff)) ? lo_clamp : run_min_ff;
      bounds.sat = sat_seen_ff | snap.sat;

      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      sat_seen_in = sat_seen_ff;
      if (take) begin
         if (snap.mend) begin
            run_min_in = gbsr_pkg::B48_MAX;
            run_max_in = gbsr_pkg::B48_MIN;
            sat_seen_in = 1'b0;
         end else begin
            run_min_in = bounds.lower;
            run_max_in = bounds.upper;
            sat_seen_in = bounds.sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff <= gbsr_pkg::B48_MAX;
         run_max_ff <= gbsr_pkg::B48_MIN;
         sat_seen_ff <= 1'b0;
      end else begin
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
         sat_seen_ff <= sat_seen_in;
      end
   end

endmodule

// ----- design/gershgorin_bounds_sparse_rows_top.sv -----
// Top level of the Gershgorin eigenvalue bounds block for streamed sparse rows.
//
// The req channel carries one nonzero matrix entry per word, rows in ascending
// order. A word with entry_valid low only closes an empty row. The word that has
// tlast high ends the matrix and causes one rsp word with the lower and upper
// bounds of all counted rows and a flag that tells whether any row radius
// saturated. The csr channel writes the number of rows in use; it is always
// ready; the user must write it only while the block is idle (not enforced).
// One req word is accepted in every cycle while req_tready is high. A word goes
// through an input register, an accumulation register and the bound registers;
// the rsp word of a matrix end is registered as it leaves the accumulation stage.
// When the receiver stalls, words without a matrix end keep flowing; a second
// matrix end waits in the accumulation stage until the pending rsp word is
// taken, and meanwhile req_tready drops once the input register is full too.
// Reset clears the row accumulators and the running bounds, empties the
// pipeline and sets the row count to 65536.
module gershgorin_bounds_sparse_rows_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [63:0] req_tdata,  // row_index, col_index, entry_value
   input  logic [1:0] req_tuser,   // entry_valid, row_end
   input  logic req_tlast,         // matrix_end
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [95:0] rsp_tdata,  // lower_bound, upper_bound
   output logic rsp_tuser,         // radius_saturated
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [16:0] csr_data
);

   typedef struct packed {
      logic signed [31:0] value;
      logic [31:0] mag;
      logic is_diag;
      logic counted;
      logic valid;
      logic rend;
      logic mend;
   } in_type;

   logic [16:0] rows_ff;

   in_type s0_ff, s0_in;
   logic s0_valid_ff, s0_valid_in;
   gbsr_pkg::snap_type s1_ff, s1_in;
   logic s1_valid_ff, s1_valid_in;

   logic [46:0] radius_ff, radius_in;
   logic signed [31:0] diag_ff, diag_in;

   gbsr_pkg::bounds_type bounds;
   gbsr_pkg::bounds_type rsp_ff;
   logic rsp_valid_ff;

   logic req_accept;
   logic out_free;
   logic s1_consume;
   logic s0_consume;

   logic [15:0] row_index;
   logic [15:0] col_index;
   logic signed [31:0] entry_value;

   logic take_diag;
   logic take_off;
   logic [47:0] rad_sum;
   logic rad_over;

   assign row_index = req_tdata[15:0];
   assign col_index = req_tdata[31:16];
   assign entry_value = req_tdata[63:32];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_consume = s1_valid_ff && (!s1_ff.mend || out_free);
   assign s0_consume = s0_valid_ff && (!s1_valid_ff || s1_consume);
   assign req_tready = !s0_valid_ff || s0_consume;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_comb begin
      s0_in.value = entry_value;
      s0_in.mag = entry_value[31] ? 32'(-entry_value) : 32'(entry_value);
      s0_in.is_diag = (row_index == col_index);
      s0_in.counted = ({1'b0, row_index} < rows_ff) && (32'(row_index) < gbsr_pkg::MAX_ROWS);
      s0_in.valid = req_tuser[0];
      s0_in.rend = req_tuser[1];
      s0_in.mend = req_tlast;
      s0_valid_in = req_accept || (s0_valid_ff && !s0_consume);
   end

   always_comb begin
      take_diag = s0_ff.counted && s0_ff.valid && s0_ff.is_diag;
      take_off = s0_ff.counted && s0_ff.valid && !s0_ff.is_diag;
      rad_sum = {1'b0, radius_ff} + {16'd0, s0_ff.mag};
      rad_over = rad_sum[47];

      s1_in.diag = take_diag ? s0_ff.value : diag_ff;
      s1_in.radius = take_off ? (rad_over ? gbsr_pkg::RAD_MAX : rad_sum[46:0]) : radius_ff;
      s1_in.fold = s0_ff.rend && s0_ff.counted;
      s1_in.mend = s0_ff.mend;
      s1_in.sat = take_off && rad_over;
      s1_valid_in = s0_consume || (s1_valid_ff && !s1_consume);

      radius_in = radius_ff;
      diag_in = diag_ff;
      if (s0_consume) begin
         if (s0_ff.rend || s0_ff.mend) begin
            radius_in = '0;
            diag_in = '0;
         end else begin
            radius_in = s1_in.radius;
            diag_in = s1_in.diag;
         end
      end
   end

   gbsr_fold u_fold (
      .clock  (clock),
      .reset  (reset),
      .take   (s1_consume),
      .snap   (s1_ff),
      .bounds (bounds)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= gbsr_pkg::ROWS_RESET;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         radius_ff <= '0;
         diag_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            rows_ff <= csr_data;
         end
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         radius_ff <= radius_in;
         diag_ff <= diag_in;
         if (s1_consume && s1_ff.mend) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s0_ff <= s0_in;
      end
      if (s0_consume) begin
         s1_ff <= s1_in;
      end
      if (s1_consume && s1_ff.mend) begin
         rsp_ff <= bounds;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_ff.upper, rsp_ff.lower};
   assign rsp_tuser = rsp_ff.sat;

   a_mend_held : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.mend && rsp_valid_ff && !rsp_tready
      |=> s1_valid_ff && s1_ff.mend)
      else $error("matrix end word left the accumulation stage while the result was stalled");

   a_row_cleared : assert property (@(posedge clock) disable iff (reset)
      s0_consume && (s0_ff.rend || s0_ff.mend) |=> radius_ff == '0 && diag_ff == '0)
      else $error("row accumulators not cleared after a row end");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_ff.mend))
      else $error("result word raised without a matrix end");

endmodule

// ----- tb/gershgorin_bounds_sparse_rows_top_tb.sv -----
// Self-checking testbench for the Gershgorin eigenvalue bounds block on streamed sparse rows.
module gershgorin_bounds_sparse_rows_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   class bounds_tracker;
      gbsr_pkg::bounds_type bounds_due[$];
      logic [16:0] row_limit;
      logic [46:0] radius;
      logic signed [31:0] diagonal;
      longint lowest;
      longint highest;
      bit saturated;
      int mismatches;
      int results_checked;
      int words_taken;

      function new();
         row_limit = gbsr_pkg::ROWS_RESET;
         mismatches = 0;
         results_checked = 0;
         words_taken = 0;
         clear_row();
         clear_bounds();
      endfunction

      function void clear_row();
         radius = '0;
         diagonal = '0;
      endfunction

      function void clear_bounds();
         lowest = longint'(gbsr_pkg::B48_MAX);
         highest = longint'(gbsr_pkg::B48_MIN);
         saturated = 1'b0;
      endfunction

      function void take_word(logic [15:0] row, logic [15:0] col, logic signed [31:0] value,
                              logic valid, logic row_end, logic matrix_end);
         longint limit;
         longint mag;
         longint hi;
         longint lo;
         bit counted;
         gbsr_pkg::bounds_type due;
         words_taken++;
         limit = (row_limit > gbsr_pkg::MAX_ROWS) ? longint'(gbsr_pkg::MAX_ROWS)
                                                  : longint'(row_limit);
         counted = longint'(row) < limit;
         if (counted && valid) begin
            if (row == col) begin
               diagonal = value;
            end else begin
               mag = (value < 0) ? -longint'(value) : longint'(value);
               if (longint'(radius) > longint'(gbsr_pkg::RAD_MAX) - mag) begin
                  radius = gbsr_pkg::RAD_MAX;
                  saturated = 1'b1;
               end else begin
                  radius = radius + mag[46:0];
               end
            end
         end
         if (row_end) begin
            if (counted) begin
               hi = longint'(diagonal) + longint'(radius);
               lo = longint'(diagonal) - longint'(radius);
               if (hi > longint'(gbsr_pkg::B48_MAX)) hi = longint'(gbsr_pkg::B48_MAX);
               if (lo < longint'(gbsr_pkg::B48_MIN)) lo = longint'(gbsr_pkg::B48_MIN);
               if (hi > highest) highest = hi;
               if (lo < lowest) lowest = lo;
            end
            clear_row();
         end
         if (matrix_end) begin
            due.lower = lowest[47:0];
            due.upper = highest[47:0];
            due.sat = saturated;
            bounds_due.push_back(due);
            clear_row();
            clear_bounds();
         end
      endfunction

      function void check_bounds(logic [47:0] lower, logic [47:0] upper, logic sat);
         gbsr_pkg::bounds_type want;
         results_checked++;
         if (bounds_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: result word with none expected: lower=%h upper=%h sat=%b",
                        lower, upper, sat);
            return;
         end
         want = bounds_due.pop_front();
         if (want.lower !== lower || want.upper !== upper || want.sat !== sat) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: result %0d: expected lower=%h upper=%h sat=%b, got %h %h %b",
                        results_checked, want.lower, want.upper, want.sat,
                        lower, upper, sat);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [16:0] csr_data = '0;

   bounds_tracker tracker = new();
   int burst_left = 0;
   int max_gap = 4;
   int settings_used = 0;
   int pattern_age = 0;
   longint cycles = 0;
   logic hold_active = 1'b0;
   logic stall_on = 1'b0;
   logic [15:0] ready_pattern = '1;

   gershgorin_bounds_sparse_rows_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_bounds(rsp_tdata[47:0], rsp_tdata[95:48], rsp_tuser);
      if (pattern_age == 15) begin
         case ($urandom_range(0, 3))
            0: ready_pattern <= '1;
            1: ready_pattern <= 16'($urandom);
            2: ready_pattern <= 16'($urandom | $urandom);
            default: ready_pattern <= 16'($urandom & $urandom);
         endcase
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
      pattern_age <= (pattern_age + 1) % 16;
      rsp_tready <= !hold_active && (!stall_on || ready_pattern[0]);
   end

   task automatic push_word(input logic [15:0] row, input logic [15:0] col,
                            input logic [31:0] value, input logic valid,
                            input logic row_end, input logic matrix_end);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, max_gap);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {value, col, row};
      req_tuser <= {row_end, valid};
      req_tlast <= matrix_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_word(row, col, value, valid, row_end, matrix_end);
      burst_left--;
   endtask

   task automatic wait_for_bounds();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.bounds_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_limit(input logic [16:0] rows);
      wait_for_bounds();
      csr_valid <= 1'b1;
      csr_data <= rows;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.row_limit = rows;
      settings_used++;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 2**20) - 2**19;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_matrix();
      int nrows;
      int row;
      int entries;
      bit cut_row_end;
      bit last;
      logic [15:0] col;
      nrows = $urandom_range(1, 6);
      row = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65500) : $urandom_range(0, 24);
      cut_row_end = ($urandom_range(0, 9) == 0);
      for (int r = 0; r < nrows; r++) begin
         last = (r == nrows - 1);
         if ($urandom_range(0, 7) == 0) begin
            push_word(row[15:0], 16'($urandom), $urandom, 1'b0,
                      !(last && cut_row_end), last);
         end else begin
            entries = $urandom_range(1, 5);
            for (int e = 0; e < entries; e++) begin
               col = ($urandom_range(0, 3) == 0) ? row[15:0] : 16'($urandom);
               push_word(row[15:0], col, rand_value(), 1'b1,
                         (e == entries - 1) && !(last && cut_row_end)
                            && ($urandom_range(0, 11) != 0),
                         last && (e == entries - 1));
            end
         end
         row += $urandom_range(1, 3);
      end
   endtask

   task automatic run_phase(input logic [16:0] rows, input int words, input bit with_hold);
      int target;
      write_row_limit(rows);
      stall_on <= ($urandom_range(0, 3) != 0);
      max_gap = $urandom_range(0, 6);
      target = tracker.words_taken + words;
      if (with_hold) begin
         fork
            begin
               hold_active <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_active <= 1'b0;
            end
            repeat (6) send_matrix();
         join
      end
      while (tracker.words_taken < target) begin
         if ($urandom_range(0, 7) == 0)
            push_word(16'($urandom), 16'($urandom), $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
         else
            send_matrix();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_word(0, 0, 32'h7FFF_FFFF, 1, 0, 0);
      push_word(0, 65535, 32'h8000_0000, 1, 0, 0);
      push_word(0, 0, 32'hFFFF_0000, 1, 1, 0);
      push_word(1, 0, 0, 0, 1, 0);
      push_word(2, 5, 32'h0000_0001, 1, 0, 0);
      push_word(3, 3, 32'h0001_0000, 1, 1, 0);
      push_word(65535, 65535, 32'h7FFF_FFFF, 1, 0, 0);
      push_word(65535, 0, 32'h8000_0000, 1, 1, 1);
      push_word(0, 0, 0, 0, 0, 1);
      push_word(4, 1, 32'h0000_0005, 1, 0, 0);
      push_word(4, 4, 32'h0000_0009, 1, 0, 1);
      push_word(5, 7, 32'hFFFF_FFFF, 0, 1, 1);
      write_row_limit(17'd0);
      push_word(0, 0, 32'h0000_0005, 1, 1, 0);
      push_word(0, 1, 32'h0000_0003, 1, 1, 1);
      write_row_limit(17'd1);
      push_word(0, 1, 32'hFFFF_FFF0, 1, 1, 0);
      push_word(1, 1, 32'h0000_0100, 1, 1, 1);

      // Two rows with extreme entries while the row limit is above the cap.
      write_row_limit(17'h1FFFF);
      max_gap = 0;
      push_word(10, 10, 32'h7FFF_FFFF, 1, 0, 0);
      push_word(10, 11, 32'h8000_0000, 1, 0, 0);
      push_word(10, 12, 0, 1, 1, 0);
      push_word(20, 20, 32'h8000_0000, 1, 0, 0);
      push_word(20, 0, 32'h8000_0000, 1, 0, 0);
      push_word(20, 21, 0, 1, 1, 1);

      run_phase(17'd65535, 170, 1'b0);
      run_phase(17'($urandom_range(1, 40)), 170, 1'b0);
      run_phase(17'($urandom_range(65537, 131071)), 170, 1'b1);
      run_phase(17'($urandom_range(0, 65536)), 170, 1'b0);
      run_phase(17'd65536, 170, 1'b0);
      wait_for_bounds();

      $display("Summary: %0d words driven, %0d result words checked, %0d row-limit settings.",
               tracker.words_taken, tracker.results_checked, settings_used);
      $display("Summary: extreme entry values, ignored, empty and unfinished rows, %s",
               "random stalls and one long receiver hold-off.");
      if (tracker.mismatches == 0 && tracker.bounds_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Mismatches: %0d, results still expected: %0d",
                  tracker.mismatches, tracker.bounds_due.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
